// ===== src/scl_pkg.sv =====
// Package for the scan code line editor: result kinds, scan code values,
// controller states and the two set-1 to ASCII tables.
// Depends on nothing; imported by the core, its checker and the testbench.
`default_nettype none

package scl_pkg;

    // Result kinds carried on the output tuser.
    localparam logic [2:0] KIND_ECHO   = 3'd0;
    localparam logic [2:0] KIND_ERASE  = 3'd1;
    localparam logic [2:0] KIND_LEFT   = 3'd2;
    localparam logic [2:0] KIND_RIGHT  = 3'd3;
    localparam logic [2:0] KIND_SCREEN = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;
    localparam logic [2:0] KIND_CHAR   = 3'd6;
    localparam logic [2:0] KIND_EMPTY  = 3'd7;

    // Scan codes with a meaning of their own.
    localparam logic [7:0] SC_F1          = 8'h3B;
    localparam logic [7:0] SC_F10         = 8'h44;
    localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
    localparam logic [7:0] SC_CTRL_BREAK  = 8'h9D;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
    localparam logic [7:0] SC_LEFT        = 8'h4B;
    localparam logic [7:0] SC_RIGHT       = 8'h4D;

    // ASCII values the editor reacts to.
    localparam logic [6:0] CH_NONE      = 7'h00;
    localparam logic [6:0] CH_BACKSPACE = 7'h08;
    localparam logic [6:0] CH_NEWLINE   = 7'h0A;
    localparam logic [6:0] CH_LOWER_L   = 7'h6C;

    // Line store geometry. The usable length is the smaller of the line
    // capacity and the largest cursor value.
    localparam int          LINE_CAP    = 63;
    localparam int          STORE_DEPTH = 64;
    localparam int          POS_W       = $clog2(STORE_DEPTH);
    localparam logic [POS_W-1:0] EFF_CAP =
        POS_W'((LINE_CAP < STORE_DEPTH - 1) ? LINE_CAP : STORE_DEPTH - 1);

    // Tables are padded to 64 rows with zeros so codes 60..63 map to nothing.
    localparam int ROM_DEPTH = 64;

    localparam logic [6:0] PLAIN_ROM [ROM_DEPTH] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] SHIFT_ROM [ROM_DEPTH] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_END,
        ST_SEND
    } scl_state_t;

endpackage

`default_nettype wire

// ===== src/scancode_line_editor_core.sv =====
// Scan code line editor core: decodes set-1 scan codes into editing
// results and keeps the current line in a 64 x 7 synchronous memory.
// Depends on scl_pkg.
//
// Usage: scan codes enter on the s_* stream, one request per byte. Results
// leave on the m_* stream: tuser is the result kind, tdata the ASCII
// character or screen index, and tlast marks the final result of a code.
// A code is taken in the idle state and decoded in the decode state, where
// its first result is loaded into the output register. Ctrl+L and an empty
// Enter pass through the end state for the closing empty-line result. Enter
// with the cursor at N above zero reads the first N entries of the line
// memory back one entry per cycle while the receiver takes results, through
// the single read port of the memory. s_tready is high only while the
// controller waits for a code, and it is high again as soon as the last
// result of the previous code sits in the output register, so a new code
// is taken while that result still waits for the receiver. When the
// receiver holds m_tready low, the output register keeps its request and
// decoding or readout pauses with it. Reset clears the modifiers, the
// cursor, the line length and the output valid; the line memory is
// not cleared, since only entries below the line length are ever read.
`default_nettype none

module scancode_line_editor_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] scan_code
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] value, [7] zero fill
    output logic [2:0]      m_tuser,   // [2:0] kind
    output logic            m_tlast    // last
);
    import scl_pkg::*;

    // Controller and editor state.
    scl_state_t       state_reg, state_next;
    logic             shift_reg, shift_next;
    logic             ctrl_reg, ctrl_next;
    logic [POS_W-1:0] cursor_reg, cursor_next;
    logic [POS_W-1:0] length_reg, length_next;

    // Accepted code, readout index and readout length.
    logic [7:0]       code_reg;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic [POS_W-1:0] rd_len_reg, rd_len_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_kind_reg, out_kind_next;
    logic [6:0]       out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;

    // Line memory with a registered read port.
    logic [6:0]       line_mem [STORE_DEPTH];
    logic [6:0]       rd_q_reg;
    logic             wr_en;

    // Decode of the accepted code.
    logic             shift_now;
    logic             ctrl_now;
    logic [6:0]       ch;
    logic             is_fn;
    logic             is_ctrl_l;
    logic             is_enter;
    logic             out_free;
    logic             decode_go;
    logic             send_go;
    logic             send_done;

    // The modifiers take effect for the code that changes them.
    always_comb
    begin
        ctrl_now  = ctrl_reg;
        shift_now = shift_reg;
        if (code_reg == SC_CTRL_MAKE)
        begin
            ctrl_now = 1'b1;
        end
        else if (code_reg == SC_CTRL_BREAK)
        begin
            ctrl_now = 1'b0;
        end
        else if (code_reg == SC_LSHIFT_MAKE || code_reg == SC_RSHIFT_MAKE)
        begin
            shift_now = 1'b1;
        end
        else if (code_reg == SC_LSHIFT_BRK || code_reg == SC_RSHIFT_BRK)
        begin
            shift_now = 1'b0;
        end
    end

    // Codes 64 and up, release codes included, map to no character; the
    // padded table rows cover codes 60 to 63.
    assign ch = (code_reg[7:6] != 2'b00) ? CH_NONE :
                shift_now ? SHIFT_ROM[code_reg[5:0]] : PLAIN_ROM[code_reg[5:0]];

    assign is_fn     = (code_reg >= SC_F1) && (code_reg <= SC_F10);
    assign is_ctrl_l = (ch != CH_NONE) && ctrl_now && (ch == CH_LOWER_L);
    assign is_enter  = (ch != CH_NONE) && !is_ctrl_l && (ch == CH_NEWLINE);

    assign out_free  = !out_valid_reg || m_tready;
    assign decode_go = (state_reg == ST_DECODE) && out_free;
    assign send_go   = (state_reg == ST_SEND) && out_free;
    assign send_done = (idx_reg == rd_len_reg - POS_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (out_free)
                begin
                    if (is_fn)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (is_ctrl_l)
                    begin
                        state_next = ST_END;
                    end
                    else if (is_enter)
                    begin
                        state_next = (cursor_reg == '0) ? ST_END : ST_SEND;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (out_free && send_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Editor updates, memory write and the loading of the output register.
    always_comb
    begin
        shift_next     = shift_reg;
        ctrl_next      = ctrl_reg;
        cursor_next    = cursor_reg;
        length_next    = length_reg;
        idx_next       = idx_reg;
        rd_len_next    = rd_len_reg;
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (decode_go)
        begin
            shift_next     = shift_now;
            ctrl_next      = ctrl_now;
            out_value_next = CH_NONE;
            out_last_next  = 1'b1;
            if (is_fn)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_SCREEN;
                out_value_next = 7'(code_reg - SC_F1);
            end
            else if (ch == CH_NONE)
            begin
                if (code_reg == SC_LEFT && cursor_reg != '0)
                begin
                    cursor_next    = cursor_reg - POS_W'(1);
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_LEFT;
                end
                else if (code_reg == SC_RIGHT && cursor_reg < length_reg)
                begin
                    cursor_next    = cursor_reg + POS_W'(1);
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_RIGHT;
                end
            end
            else if (is_ctrl_l)
            begin
                shift_next     = 1'b0;
                ctrl_next      = 1'b0;
                cursor_next    = '0;
                length_next    = '0;
                out_valid_next = 1'b1;
                out_kind_next  = KIND_CLEAR;
                out_last_next  = 1'b0;
            end
            else if (ch == CH_BACKSPACE)
            begin
                if (cursor_reg != '0)
                begin
                    cursor_next    = cursor_reg - POS_W'(1);
                    length_next    = cursor_reg - POS_W'(1);
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ERASE;
                end
            end
            else if (is_enter)
            begin
                // The line is cut at the cursor; readout starts at entry 0.
                rd_len_next    = cursor_reg;
                idx_next       = '0;
                shift_next     = 1'b0;
                ctrl_next      = 1'b0;
                cursor_next    = '0;
                length_next    = '0;
                out_valid_next = 1'b1;
                out_kind_next  = KIND_ECHO;
                out_value_next = CH_NEWLINE;
                out_last_next  = 1'b0;
            end
            else if (cursor_reg < EFF_CAP)
            begin
                wr_en          = 1'b1;
                cursor_next    = cursor_reg + POS_W'(1);
                if (length_reg < cursor_reg + POS_W'(1))
                begin
                    length_next = cursor_reg + POS_W'(1);
                end
                out_valid_next = 1'b1;
                out_kind_next  = KIND_ECHO;
                out_value_next = ch;
            end
        end
        else if (state_reg == ST_END && out_free)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_EMPTY;
            out_value_next = CH_NONE;
            out_last_next  = 1'b1;
        end
        else if (send_go)
        begin
            // rd_q_reg holds entry idx_reg, read in the previous cycle.
            out_valid_next = 1'b1;
            out_kind_next  = KIND_CHAR;
            out_value_next = rd_q_reg;
            out_last_next  = send_done;
            idx_next       = idx_reg + POS_W'(1);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shift_reg     <= 1'b0;
            ctrl_reg      <= 1'b0;
            cursor_reg    <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            ctrl_reg      <= ctrl_next;
            cursor_reg    <= cursor_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            code_reg <= s_tdata;
        end
        idx_reg       <= idx_next;
        rd_len_reg    <= rd_len_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    // The read address follows the next readout index so each entry is registered
    // before it is sent. Writes come only from decode cycles and readout runs in
    // the send state, so a readout never meets a write to the same entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[cursor_reg] <= ch;
        end
        rd_q_reg <= line_mem[idx_next];
    end

endmodule

`default_nettype wire

// ===== src/scl_checker.sv =====
// Port-level checker for the scan code line editor core, bound to it below.
// Depends on scl_pkg and on the port list of scancode_line_editor_core.
`default_nettype none

module scl_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [2:0] m_tuser,
    input wire logic       m_tlast
);
    import scl_pkg::*;

    // A stalled result request keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // One code is decoded at a time.
    a_one_code: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second code taken during decode");

    // A screen switch is alone and names one of ten screens.
    a_screen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_SCREEN |-> m_tlast && m_tdata <= 8'd9)
        else $error("bad screen switch result");

    // A clear is not marked last, since an empty line end follows it.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_CLEAR |-> !m_tlast)
        else $error("clear marked as last");

    // Ending an empty line closes the request group.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_EMPTY |-> m_tlast && m_tdata == 8'd0)
        else $error("bad empty line end");

endmodule

bind scancode_line_editor_core scl_checker u_scl_checker (.*);

`default_nettype wire

// ===== verif/scancode_line_editor_core_tb.sv =====
// Self-checking testbench for the scan code line editor core.
// Drives scan codes on the input stream, predicts every editing result
// in the bench itself, and checks the output stream field by field.
// Depends on scl_pkg and scancode_line_editor_core.
`timescale 1ns / 100ps

module scancode_line_editor_core_tb;

    import scl_pkg::*;

    // Scan codes used by the directed tests that have no name in the package.
    localparam logic [7:0] KEY_ESC       = 8'h01;
    localparam logic [7:0] KEY_ONE       = 8'h02;
    localparam logic [7:0] KEY_BACKSPACE = 8'h0E;
    localparam logic [7:0] KEY_TAB       = 8'h0F;
    localparam logic [7:0] KEY_Q         = 8'h10;
    localparam logic [7:0] KEY_ENTER     = 8'h1C;
    localparam logic [7:0] KEY_A         = 8'h1E;
    localparam logic [7:0] KEY_L         = 8'h26;
    localparam logic [7:0] KEY_B         = 8'h30;
    localparam logic [7:0] KEY_SPACE     = 8'h39;

    // The line can never grow past the last cursor value of the store.
    localparam int LINE_LIMIT = (LINE_CAP < STORE_DEPTH - 1) ? LINE_CAP : STORE_DEPTH - 1;

    // Quiet cycles allowed after the last result before the verdict.
    localparam int SETTLE_CYCLES = 40;

    // Set-1 to ASCII tables, rows 60..63 empty.
    localparam logic [6:0] PLAIN_MAP [64] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] SHIFTED_MAP [64] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] value;
        logic       last;
    } editor_result_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    // Predicted editor state, kept next to the block's own.
    logic       shift_down;
    logic       ctrl_down;
    logic [6:0] line_chars [STORE_DEPTH];
    int         cursor;
    int         line_len;

    editor_result_t pending_results [$];
    int             error_count = 0;
    // When set, neither side inserts gaps.
    bit             no_idle = 1'b0;

    scancode_line_editor_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] scan_code
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [6:0] value, [7] zero fill
        .m_tuser  (m_tuser),   // [2:0] kind
        .m_tlast  (m_tlast)    // last
    );

    always #1 clk = ~clk;

    // Backstop for a hung handshake. The slowest legal run is far shorter.
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Gap length in cycles: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(input string what, input editor_result_t got,
                                   input editor_result_t want);
        error_count++;
        if (error_count <= 40)
            $display("%0t ns: %s: got kind %0d value 0x%02h last %0b, wanted kind %0d value 0x%02h last %0b",
                     $time, what, got.kind, got.value, got.last,
                     want.kind, want.value, want.last);
    endtask

    // Works out the results that one accepted scan code causes and queues
    // them behind the ones still outstanding.
    task automatic predict_edit(input logic [7:0] code);
        editor_result_t batch [$];
        logic [6:0]     ch;
        int             i;

        if (code == SC_CTRL_MAKE)
            ctrl_down = 1'b1;
        else if (code == SC_CTRL_BREAK)
            ctrl_down = 1'b0;
        else if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE)
            shift_down = 1'b1;
        else if (code == SC_LSHIFT_BRK || code == SC_RSHIFT_BRK)
            shift_down = 1'b0;

        ch = CH_NONE;
        if (code < 8'd60)
            ch = shift_down ? SHIFTED_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];

        if (code >= SC_F1 && code <= SC_F10)
            batch.push_back('{KIND_SCREEN, 7'(code - SC_F1), 1'b0});

        if (ch == CH_NONE)
        begin
            if (code == SC_LEFT && cursor > 0)
            begin
                cursor--;
                batch.push_back('{KIND_LEFT, 7'd0, 1'b0});
            end
            else if (code == SC_RIGHT && cursor < line_len)
            begin
                cursor++;
                batch.push_back('{KIND_RIGHT, 7'd0, 1'b0});
            end
        end
        else if (ctrl_down && ch == CH_LOWER_L)
        begin
            batch.push_back('{KIND_CLEAR, 7'd0, 1'b0});
            batch.push_back('{KIND_EMPTY, 7'd0, 1'b0});
            shift_down = 1'b0;
            ctrl_down  = 1'b0;
            cursor     = 0;
            line_len   = 0;
        end
        else if (ch == CH_BACKSPACE)
        begin
            if (cursor > 0)
            begin
                cursor--;
                line_len = cursor;
                batch.push_back('{KIND_ERASE, 7'd0, 1'b0});
            end
        end
        else if (ch == CH_NEWLINE)
        begin
            // The line is cut at the cursor, so only the part before it goes out.
            batch.push_back('{KIND_ECHO, CH_NEWLINE, 1'b0});
            if (cursor == 0)
                batch.push_back('{KIND_EMPTY, 7'd0, 1'b0});
            for (i = 0; i < cursor; i++)
                batch.push_back('{KIND_CHAR, line_chars[i], 1'b0});
            shift_down = 1'b0;
            ctrl_down  = 1'b0;
            cursor     = 0;
            line_len   = 0;
        end
        else if (cursor < LINE_LIMIT)
        begin
            // Overwrite at the cursor; the length only ever grows here.
            line_chars[cursor] = ch;
            cursor++;
            if (line_len < cursor)
                line_len = cursor;
            batch.push_back('{KIND_ECHO, ch, 1'b0});
        end

        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            pending_results.push_back(batch[k]);
    endtask

    // Offers one scan code and waits for the block to take it. The valid is
    // left high so that a following code without a gap goes out back to back.
    task automatic send_code(input logic [7:0] code);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_edit(code);
    endtask

    // Receiver: ready runs of random length broken by random stalls.
    initial
    begin
        int run;
        int stall;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Every result leaving the block is matched against the oldest prediction.
    always @(posedge clk)
    begin
        editor_result_t got;
        editor_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[6:0], m_tlast};
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", got, '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind || m_tdata !== {1'b0, want.value} ||
                    m_tlast !== want.last)
                    report_mismatch("result mismatch", got, want);
            end
        end
    end

    // Byte range ends, both sides of the release bit, and a padded row.
    task automatic test_code_extremes();
        send_code(8'h00);
        send_code(8'hFF);
        send_code(8'h7F);
        send_code(8'h80);
        send_code(8'h3C);
    endtask

    task automatic test_screen_keys();
        send_code(SC_F1);
        send_code(SC_F10);
    endtask

    // Cursor moves, the arrows at both ends of the line, backspace at the
    // start and in the middle, tab and escape stored as characters, and
    // an Enter that reads out one character.
    task automatic test_cursor_editing();
        send_code(KEY_A);
        send_code(KEY_TAB);
        send_code(KEY_ESC);
        send_code(SC_RIGHT);
        send_code(SC_LEFT);
        send_code(KEY_B);
        send_code(SC_LEFT);
        send_code(KEY_BACKSPACE);
        send_code(SC_LEFT);
        send_code(SC_LEFT);
        send_code(KEY_BACKSPACE);
        send_code(SC_RIGHT);
        send_code(KEY_ENTER);
    endtask

    // Both shift keys, control with and without shift, and Ctrl+L.
    task automatic test_modifiers();
        send_code(SC_LSHIFT_MAKE);
        send_code(KEY_Q);
        send_code(SC_LSHIFT_BRK);
        send_code(SC_RSHIFT_MAKE);
        send_code(KEY_ONE);
        send_code(SC_CTRL_MAKE);
        send_code(KEY_L);
        send_code(SC_RSHIFT_BRK);
        send_code(KEY_L);
        send_code(SC_CTRL_MAKE);
        send_code(SC_CTRL_BREAK);
        send_code(KEY_L);
        send_code(SC_CTRL_MAKE);
        send_code(KEY_L);
        send_code(KEY_ENTER);
    endtask

    // Fills the line to the cap, tries one more, steps back to overwrite one
    // character and ends it, and then types and reads out another full line.
    task automatic test_full_line();
        int i;
        for (i = 0; i <= LINE_LIMIT; i++)
            send_code(8'($urandom_range(KEY_Q, KEY_Q + 9)));
        send_code(SC_LEFT);
        send_code(SC_LEFT);
        send_code(KEY_SPACE);
        send_code(SC_RIGHT);
        send_code(KEY_ENTER);
        for (i = 0; i < LINE_LIMIT; i++)
            send_code(8'($urandom_range(KEY_A, KEY_A + 8)));
        send_code(KEY_ENTER);
    endtask

    // Mostly typing and editing keys that build real lines, with a share of
    // arbitrary bytes, releases and modifiers.
    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 52)
            return 8'($urandom_range(1, 8'h39));
        if (r < 64)
            return ($urandom_range(0, 1) != 0) ? SC_LEFT : SC_RIGHT;
        if (r < 69)
            return KEY_BACKSPACE;
        if (r < 73)
            return KEY_ENTER;
        if (r < 81)
        begin
            case ($urandom_range(0, 5))
                0:       return SC_CTRL_MAKE;
                1:       return SC_CTRL_BREAK;
                2:       return SC_LSHIFT_MAKE;
                3:       return SC_RSHIFT_MAKE;
                4:       return SC_LSHIFT_BRK;
                default: return SC_RSHIFT_BRK;
            endcase
        end
        if (r < 85)
            return 8'($urandom_range(SC_F1, SC_F10));
        if (r < 89)
            return KEY_L;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_random_editing(input int count);
        repeat (count) send_code(pick_code());
    endtask

    // A stretch with both sides always ready.
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        repeat (count) send_code(pick_code());
        no_idle = 1'b0;
    endtask

    initial
    begin
        shift_down = 1'b0;
        ctrl_down  = 1'b0;
        cursor     = 0;
        line_len   = 0;
        foreach (line_chars[i])
            line_chars[i] = 7'd0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_code_extremes();
        test_screen_keys();
        test_cursor_editing();
        test_modifiers();
        test_full_line();
        test_random_editing(50);
        test_back_to_back(25);
        test_random_editing(10);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
